// ===== src/afl_pkg.sv =====
package afl_pkg;

  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned DELAY_W = 20;
  localparam int unsigned TIME_W  = 31;
  localparam int unsigned CFG_W   = 9;

  // Delay assumed for every frame when all loaded delays are zero
  localparam logic [DELAY_W-1:0] DEFAULT_DELAY_MS = DELAY_W'(100);

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } afl_action_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } afl_op_e;

  typedef struct packed {
    afl_action_e         action;
    logic [SLOT_W-1:0]   frame_slot;
    logic [DELAY_W-1:0]  delay_ms;
    logic [TIME_W-1:0]   time_ms;
    logic                loop_mode;
  } afl_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   frame_index;
    logic                frame_valid;
    logic [DELAY_W-1:0]  ms_to_next;
    logic                next_valid;
  } afl_rsp_t;

endpackage

// ===== src/animation_frame_time_lookup_unit.sv =====
// Animation frame time lookup. Holds one display delay per frame in a
// MAX_FRAMES-deep memory and answers time queries with the frame shown at
// that time and the milliseconds until the next frame. A load request is
// written to the memory without leaving the idle state. A query runs in
// steps: the total is summed over one memory read port, one cycle per
// frame; when looping, the wrap is a restoring remainder, one time bit per
// cycle; and the frame walk subtracts one delay per cycle until the time
// falls inside a frame. The sum, the wrap and the walk share one
// add/subtract unit. After reset the block clears the whole delay memory,
// and after a frame_count write it clears the slots at and above the new
// count; requests are held off meanwhile.
// A finished result waits in an output register, so the next request is
// taken while it is still pending.
module animation_frame_time_lookup_unit #(
  parameter int unsigned MAX_FRAMES = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  afl_pkg::afl_req_t          req_i,
  output logic                       rsp_valid_o,
  input  logic                       rsp_ready_i,
  output afl_pkg::afl_rsp_t          rsp_o,
  input  logic                       cfg_we_i,
  input  logic [afl_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import afl_pkg::*;

  localparam int unsigned AW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned VW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned TOT_W = DELAY_W + AW;
  localparam int unsigned UW    = ((TOT_W > TIME_W) ? TOT_W : TIME_W) + 1;
  localparam int unsigned BIT_W = $clog2(TIME_W);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CLEAR = 8'b0000_0010,
    ST_SUM   = 8'b0000_0100,
    ST_MOD   = 8'b0000_1000,
    ST_CHECK = 8'b0001_0000,
    ST_WALK  = 8'b0010_0000,
    ST_DIFF  = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic               pend_q, pend_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic               use_def_q, use_def_d;
  logic               loop_q, loop_d;
  logic [TIME_W-1:0]  t_q, t_d;
  logic [UW-1:0]      acc_q, acc_d;
  logic [UW-1:0]      rem_q, rem_d;
  afl_rsp_t           res_q, res_d;
  afl_rsp_t           rsp_q;
  logic               rsp_valid_q, rsp_valid_d;
  logic               rsp_load;

  afl_op_e            alu_op;
  logic [UW-1:0]      alu_a, alu_b, alu_res;
  logic               alu_borrow;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [DELAY_W-1:0] mem_wdata, mem_rdata;

  logic [VW-1:0]      cfg_ext, slot_ext;
  logic               cfg_sat, cfg_below_max;
  logic [CNT_W-1:0]   cfg_n;
  logic               slot_ok;
  logic [CNT_W-1:0]   idx_inc;
  logic [UW-1:0]      d_ext, cnt_ext, def_total;

  afl_alu #(
    .WIDTH(UW)
  ) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .borrow_o(alu_borrow)
  );

  afl_mem #(
    .DEPTH(MAX_FRAMES),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Saturate the frame count write at the table depth
  assign cfg_ext       = VW'(cfg_wdata_i);
  assign cfg_sat       = cfg_ext > VW'(MAX_FRAMES);
  assign cfg_n         = cfg_sat ? CNT_W'(MAX_FRAMES) : cfg_ext[CNT_W-1:0];
  assign cfg_below_max = cfg_ext < VW'(MAX_FRAMES);

  // Drop loads to slots outside the frames in use
  assign slot_ext = VW'(req_i.frame_slot);
  assign slot_ok  = (slot_ext < VW'(count_q)) && (slot_ext < VW'(MAX_FRAMES));

  assign idx_inc   = idx_q + 1'b1;
  assign d_ext     = use_def_q ? UW'(DEFAULT_DELAY_MS) : UW'(mem_rdata);
  // Default total: count * 100 as shifts and adds
  assign cnt_ext   = UW'(count_q);
  assign def_total = (cnt_ext << 6) + (cnt_ext << 5) + (cnt_ext << 2);

  assign req_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    clr_d     = clr_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    bit_d     = bit_q;
    use_def_d = use_def_q;
    loop_d    = loop_q;
    t_d       = t_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    res_d     = res_q;
    rsp_load  = 1'b0;
    alu_op    = ALU_SUB;
    alu_a     = '0;
    alu_b     = '0;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = idx_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (req_i.action == ACT_LOAD) begin
            if (slot_ok) begin
              mem_we    = 1'b1;
              mem_waddr = slot_ext[AW-1:0];
              mem_wdata = req_i.delay_ms;
            end
          end else if (count_q == '0) begin
            res_d.frame_index = '0;
            res_d.frame_valid = 1'b1;
            res_d.ms_to_next  = '0;
            res_d.next_valid  = 1'b0;
            state_d           = ST_EMIT;
          end else begin
            // Start the sum pass: read slot 0 now
            t_d       = req_i.time_ms;
            loop_d    = req_i.loop_mode;
            acc_d     = '0;
            mem_re    = 1'b1;
            mem_raddr = '0;
            idx_d     = CNT_W'(1);
            pend_d    = 1'b1;
            state_d   = ST_SUM;
          end
        end
      end

      ST_SUM: begin
        alu_op = ALU_ADD;
        alu_a  = acc_q;
        alu_b  = UW'(mem_rdata);
        if (pend_q) begin
          acc_d = alu_res;
        end
        if (idx_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q[AW-1:0];
          idx_d     = idx_inc;
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (!pend_q) begin
          use_def_d = (acc_q == '0);
          if (acc_q == '0) begin
            acc_d = def_total;
          end
          if (loop_q) begin
            rem_d   = '0;
            bit_d   = BIT_W'(TIME_W - 1);
            state_d = ST_MOD;
          end else begin
            rem_d   = UW'(t_q);
            state_d = ST_CHECK;
          end
        end
      end

      ST_MOD: begin
        // Restoring remainder, one time bit per cycle
        alu_a = {rem_q[UW-2:0], t_q[bit_q]};
        alu_b = acc_q;
        rem_d = alu_borrow ? alu_a : alu_res;
        if (bit_q == '0) begin
          state_d = ST_CHECK;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end

      ST_CHECK: begin
        alu_a = acc_q;
        alu_b = rem_q;
        if (alu_borrow) begin
          // Past the end without looping
          res_d.frame_index = '0;
          res_d.frame_valid = 1'b0;
          res_d.ms_to_next  = '0;
          res_d.next_valid  = 1'b0;
          state_d           = ST_EMIT;
        end else begin
          idx_d     = '0;
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_d   = ST_WALK;
        end
      end

      ST_WALK: begin
        alu_a = rem_q;
        alu_b = d_ext;
        if (alu_borrow) begin
          // Time falls inside this frame; hold the read data for the diff
          state_d = ST_DIFF;
        end else begin
          rem_d = alu_res;
          if (idx_inc == count_q) begin
            // Exactly at the end: last frame, no next time
            res_d.frame_index = SLOT_W'(count_q - 1'b1);
            res_d.frame_valid = 1'b1;
            res_d.ms_to_next  = '0;
            res_d.next_valid  = 1'b0;
            state_d           = ST_EMIT;
          end else begin
            idx_d     = idx_inc;
            mem_re    = 1'b1;
            mem_raddr = idx_inc[AW-1:0];
          end
        end
      end

      ST_DIFF: begin
        alu_a             = d_ext;
        alu_b             = rem_q;
        res_d.frame_index = SLOT_W'(idx_q);
        res_d.frame_valid = 1'b1;
        res_d.ms_to_next  = alu_res[DELAY_W-1:0];
        res_d.next_valid  = 1'b1;
        state_d           = ST_EMIT;
      end

      ST_EMIT: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == AW'(MAX_FRAMES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Frame count write: restart the clear pass from the lowest slot still dirty
    if (cfg_we_i && (state_q == ST_IDLE || state_q == ST_CLEAR)) begin
      count_d = cfg_n;
      if (cfg_below_max) begin
        state_d = ST_CLEAR;
        if (state_q == ST_CLEAR && clr_q < cfg_n[AW-1:0]) begin
          clr_d = clr_q;
        end else begin
          clr_d = cfg_n[AW-1:0];
        end
      end
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      count_q     <= '0;
      clr_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      bit_q       <= '0;
      use_def_q   <= 1'b0;
      loop_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      clr_q       <= clr_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      bit_q       <= bit_d;
      use_def_q   <= use_def_d;
      loop_q      <= loop_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q   <= t_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    res_q <= res_d;
    if (rsp_load) begin
      rsp_q <= res_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== src/afl_alu.sv =====
module afl_alu #(
  parameter int unsigned WIDTH = 32
) (
  input  afl_pkg::afl_op_e   op_i,
  input  logic [WIDTH-1:0]   a_i,
  input  logic [WIDTH-1:0]   b_i,
  output logic [WIDTH-1:0]   res_o,
  output logic               borrow_o
);
  import afl_pkg::*;

  logic [WIDTH:0] full;

  always_comb begin
    case (op_i)
      ALU_ADD: full = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: full = {1'b0, a_i} - {1'b0, b_i};
      default: full = '0;
    endcase
  end

  assign res_o    = full[WIDTH-1:0];
  // Top bit flags a < b on subtract
  assign borrow_o = (op_i == ALU_SUB) && full[WIDTH];

endmodule

// ===== src/afl_mem.sv =====
module afl_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [afl_pkg::DELAY_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [afl_pkg::DELAY_W-1:0] rdata_o
);
  import afl_pkg::*;

  logic [DELAY_W-1:0] mem_q [DEPTH];
  logic [DELAY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== verif/afl_lookup_checker.sv =====
module afl_lookup_checker #(
  parameter int unsigned MAX_FRAMES = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  logic                       req_ready_i,
  input  afl_pkg::afl_req_t          req_i,
  input  logic                       rsp_valid_i,
  input  logic                       rsp_ready_i,
  input  afl_pkg::afl_rsp_t          rsp_i,
  input  logic                       cfg_we_i,
  input  logic [afl_pkg::CFG_W-1:0]  cfg_wdata_i,
  output int unsigned                err_count_o,
  output int unsigned                pending_o,
  output int unsigned                checked_o,
  output int unsigned                span_ms_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import afl_pkg::*;

  logic [DELAY_W-1:0] delay_tab [MAX_FRAMES];
  logic [27:0]        delay_sum;
  int unsigned        frames_used;
  afl_rsp_t           frame_answers_q [$];
  int unsigned        mismatches;
  int unsigned        answers_seen;

  // Frame shown at the requested time and the distance to the next frame.
  function automatic afl_rsp_t lookup_frame(afl_req_t q);
    afl_rsp_t        r;
    logic            use_default;
    longint unsigned span;
    longint unsigned t;
    longint unsigned d;
    r = '0;
    if (frames_used == 0) begin
      r.frame_valid = 1'b1;
      return r;
    end
    use_default = (delay_sum == '0);
    span = use_default ? longint'(DEFAULT_DELAY_MS) * frames_used : longint'(delay_sum);
    t = longint'(q.time_ms);
    if (q.loop_mode) t = t % span;
    if (t > span) return r;
    r.frame_valid = 1'b1;
    for (int unsigned i = 0; i < frames_used; i++) begin
      d = use_default ? longint'(DEFAULT_DELAY_MS) : longint'(delay_tab[i]);
      if (t < d) begin
        r.frame_index = SLOT_W'(i);
        r.ms_to_next  = DELAY_W'(d - t);
        r.next_valid  = 1'b1;
        return r;
      end
      t -= d;
    end
    r.frame_index = SLOT_W'(frames_used - 1);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    int unsigned n;
    afl_rsp_t    want;
    logic        bad;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < MAX_FRAMES; i++) delay_tab[i] = '0;
      delay_sum    = '0;
      frames_used  = 0;
      mismatches   = 0;
      answers_seen = 0;
      frame_answers_q.delete();
    end else begin
      if (cfg_we_i) begin
        n = (32'(cfg_wdata_i) > MAX_FRAMES) ? MAX_FRAMES : 32'(cfg_wdata_i);
        for (int unsigned i = n; i < MAX_FRAMES; i++) begin
          delay_sum    = delay_sum - 28'(delay_tab[i]);
          delay_tab[i] = '0;
        end
        frames_used = n;
      end
      // Pop before queueing so an answer cannot match a query accepted in the same cycle.
      if (rsp_valid_i && rsp_ready_i) begin
        answers_seen++;
        if (frame_answers_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] answer with no query waiting: frame %0d/%0b next %0d/%0b",
                     $realtime, rsp_i.frame_index, rsp_i.frame_valid,
                     rsp_i.ms_to_next, rsp_i.next_valid);
        end else begin
          want = frame_answers_q.pop_front();
          bad = (rsp_i.frame_index !== want.frame_index) ||
                (rsp_i.frame_valid !== want.frame_valid) ||
                (rsp_i.ms_to_next  !== want.ms_to_next)  ||
                (rsp_i.next_valid  !== want.next_valid);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"[%0t] answer %0d: expected frame %0d/%0b next %0d/%0b,",
                        " got %0d/%0b next %0d/%0b"},
                       $realtime, answers_seen, want.frame_index, want.frame_valid,
                       want.ms_to_next, want.next_valid, rsp_i.frame_index,
                       rsp_i.frame_valid, rsp_i.ms_to_next, rsp_i.next_valid);
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        if (req_i.action == ACT_LOAD) begin
          if (32'(req_i.frame_slot) < frames_used &&
              32'(req_i.frame_slot) < MAX_FRAMES) begin
            delay_sum = delay_sum - 28'(delay_tab[req_i.frame_slot]) +
                        28'(req_i.delay_ms);
            delay_tab[req_i.frame_slot] = req_i.delay_ms;
          end
        end else begin
          frame_answers_q = {frame_answers_q, lookup_frame(req_i)};
        end
      end
    end
    err_count_o <= mismatches;
    pending_o   <= frame_answers_q.size();
    checked_o   <= answers_seen;
    span_ms_o   <= (delay_sum == '0) ? 32'(DEFAULT_DELAY_MS) * frames_used
                                     : 32'(delay_sum);
  end

endmodule

// ===== verif/animation_frame_time_lookup_unit_tb.sv =====
module animation_frame_time_lookup_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import afl_pkg::*;

  localparam int unsigned     MAX_FRAMES  = 256;
  // Settle this long before a write, to outlast the longest query (256 frames,
  // looping) and the clearing pass after a frame-count write.
  localparam int unsigned     SETTLE_CYC  = 600;
  localparam longint unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned     ITEM_GOAL   = 1000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             req_valid_i = 1'b0;
  logic             req_ready_o;
  afl_req_t         req_i       = '0;
  logic             rsp_valid_o;
  logic             rsp_ready_i = 1'b0;
  afl_rsp_t         rsp_o;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  int unsigned     err_count;
  int unsigned     pending;
  int unsigned     checked;
  int unsigned     span_ms;

  int unsigned     frames_set;
  int unsigned     n_queries;
  int unsigned     n_loads;
  int unsigned     n_ignored;
  int unsigned     n_cfg;
  int unsigned     n_phases;
  int unsigned     rsp_hold;
  longint unsigned cycles;
  bit              steady;

  animation_frame_time_lookup_unit #(
    .MAX_FRAMES (MAX_FRAMES)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  afl_lookup_checker #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_lookup_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_i (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_i (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_i       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .span_ms_o   (span_ms)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycles, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long stretch.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 24);
    return $urandom_range(40, 300);
  endfunction

  // Receiver back-pressure: start a stall after an accepted answer or at random
  // while idle; hold ready low for the stall length. Steady phases never stall.
  always @(posedge clk_i) begin
    if (rsp_hold != 0)
      rsp_hold--;
    else if (!steady && ((rsp_valid_o && rsp_ready_i) || $urandom_range(0, 7) == 0))
      rsp_hold = pick_gap();
    rsp_ready_i <= (rsp_hold == 0);
  end

  // Load request; time and loop fields are don't-care, so fill them randomly.
  function automatic afl_req_t load_req(int unsigned slot, int unsigned delay);
    afl_req_t r;
    r.action     = ACT_LOAD;
    r.frame_slot = SLOT_W'(slot);
    r.delay_ms   = DELAY_W'(delay);
    r.time_ms    = TIME_W'($urandom);
    r.loop_mode  = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic afl_req_t query_req(longint unsigned t, bit wrap);
    afl_req_t r;
    r.action     = ACT_QUERY;
    r.frame_slot = SLOT_W'($urandom);
    r.delay_ms   = DELAY_W'($urandom);
    r.time_ms    = TIME_W'(t);
    r.loop_mode  = wrap;
    return r;
  endfunction

  // Delay flavors per phase: all zero (default frame length), short with
  // zeros mixed in, anywhere in range, and extremes of the field.
  function automatic int unsigned pick_delay(int unsigned flavor);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (flavor)
      0: begin
        return 0;
      end
      1: begin
        return (roll < 20) ? 0 : $urandom_range(1, 50);
      end
      2: begin
        return $urandom_range(0, 655350);
      end
      default: begin
        if (roll < 15) return 0;
        if (roll < 30) return 20'hFFFFF;
        if (roll < 45) return 655350;
        return $urandom_range(1, 1000);
      end
    endcase
  endfunction

  // Times cluster around the end of the animation, where the corner cases are.
  function automatic longint unsigned pick_time();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 0;
    if (roll < 25) return span_ms;
    if (roll < 32) return span_ms + 1;
    if (roll < 40) return (span_ms == 0) ? 0 : span_ms - 1;
    if (roll < 55) return $urandom & 32'h7FFF_FFFF;
    return $urandom_range(0, span_ms + span_ms / 4 + 1);
  endfunction

  // Present one request and hold it until accepted. Leave valid high so a
  // back-to-back request needs no second assignment in the same step.
  task automatic send_request(afl_req_t r);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    do @(posedge clk_i); while (!req_ready_o);
    if (r.action == ACT_QUERY)
      n_queries++;
    else if (r.frame_slot < frames_set)
      n_loads++;
    else
      n_ignored++;
  endtask

  task automatic query(longint unsigned t, bit wrap);
    send_request(query_req(t, wrap));
  endtask

  task automatic load(int unsigned slot, int unsigned delay);
    send_request(load_req(slot, delay));
  endtask

  // Write the frame count only with the block idle: drain every answer, then
  // wait out a trailing load or an earlier clearing pass.
  task automatic set_frame_count(int unsigned value);
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    frames_set = (value > MAX_FRAMES) ? MAX_FRAMES : value;
    n_cfg++;
  endtask

  initial begin : stimulus
    int unsigned count;
    int unsigned flavor;
    int unsigned ops;
    int unsigned roll;
    int unsigned big_phases;
    big_phases = 0;
    frames_set = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // No frames configured, with and without looping.
    query(0, 1'b0);
    query(12345, 1'b1);

    // Three frames, all delays zero: each counts as 100 ms, total 300.
    set_frame_count(3);
    query(0, 1'b0);
    query(299, 1'b0);
    query(300, 1'b0);   // exactly at the end
    query(301, 1'b0);   // past the end
    query(1000, 1'b1);

    // Zero-length middle frame, long last frame (655350 ms), loads outside count.
    load(0, 10);
    load(1, 0);
    load(2, 655350);
    load(3, 7);
    load(255, 5);
    query(9, 1'b0);
    query(10, 1'b0);
    query(655360, 1'b0);
    query(655361, 1'b0);
    query(32'h7FFF_FFFF, 1'b1);
    query(32'h7FFF_FFFF, 1'b0);

    // Count above the limit saturates; fill the top slot with an all-ones delay.
    set_frame_count(300);
    load(255, 20'hFFFFF);
    query(655360, 1'b0);
    query(655360 + 20'hFFFFF, 1'b0);

    // Lowering the count drops slot 2 and slot 255 from the total.
    set_frame_count(2);
    query(5, 1'b1);
    query(10, 1'b0);
    query(11, 1'b0);

    set_frame_count(511);
    query(25, 1'b1);

    // Random phases: set a count, fill the table, then mix queries and loads.
    while (n_queries + n_loads < ITEM_GOAL) begin
      roll = $urandom_range(0, 99);
      if (roll < 5)
        count = 0;
      else if (roll < 10 && big_phases < 3) begin
        count = (big_phases == 0) ? MAX_FRAMES : $urandom_range(MAX_FRAMES, 511);
        big_phases++;
      end else if (roll < 20)
        count = 1;
      else if (roll < 28)
        count = $urandom_range(17, 64);
      else
        count = $urandom_range(2, 16);
      steady = ($urandom_range(0, 3) == 0);
      set_frame_count(count);
      n_phases++;
      flavor = $urandom_range(0, 3);
      if (flavor != 0) begin
        for (int unsigned s = 0; s < frames_set; s++) load(s, pick_delay(flavor));
      end
      ops = (frames_set > 64) ? 20 : $urandom_range(30, 80);
      repeat (ops) begin
        roll = $urandom_range(0, 99);
        if (roll < 65 || frames_set == 0 && roll < 90)
          query(pick_time(), 1'($urandom_range(0, 1)));
        else if (roll < 90)
          load($urandom_range(0, frames_set - 1), pick_delay(flavor));
        else
          load($urandom_range(frames_set, 255), pick_delay(3));
      end
    end
    steady = 1'b0;

    // Drop valid, drain the answers, then let the block settle.
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("covered %0d queries, %0d table loads, %0d ignored loads,",
             n_queries, n_loads, n_ignored);
    $display("%0d count writes, %0d phases, %0d answers checked, %0d mismatches, %0d cycles",
             n_cfg, n_phases, checked, err_count, cycles);
    if (err_count == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
